// ===== src/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the running median filter
// Sizes of the sorted cell chain, the entry held by one cell and the
// control bundle broadcast along the chain each cycle.
// ----------------------------------------------------------------------------
package swm_pkg;

  // largest window and sample width
  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 32;

  // window size register
  localparam int CFG_W     = 7;
  localparam int CFG_RESET = 3;

  // derived widths
  localparam int AGE_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int SZ_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int MED_N   = (WINDOW_MAX + 1) / 2;
  localparam int MID_W   = (MED_N > 1) ? $clog2(MED_N) : 1;
  localparam int LVL_N   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 0;
  localparam int TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

  // one sorted entry: valid flag, age tag, sample value
  typedef struct packed {
    logic                       vld;
    logic [AGE_W-1:0]           age;
    logic signed [SAMPLE_W-1:0] key;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic                       en;       // cells update this cycle
    logic                       insert;   // new sample goes in
    logic                       aging;    // survivors age by one
    logic                       clear;    // window emptied first
    logic [AGE_W-1:0]           tgt_age;  // entry of this age is removed
    logic signed [SAMPLE_W-1:0] new_key;
  } step_ctrl_t;

endpackage

// ===== src/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell: one position of the sorted window chain
// Holds one entry; each update takes its own entry or a neighbor's entry,
// or the new sample, so the chain stays sorted after a remove and insert.
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  swm_pkg::step_ctrl_t ctrl,
  input  swm_pkg::entry_t     below,      // entry of the next lower position
  input  swm_pkg::entry_t     above,      // entry of the next higher position
  input  logic                dle_self,   // removal at or below this position
  input  logic                dle_below,  // removal at or below the lower position
  input  logic                ins_self,   // new sample lands at or below here
  input  logic                ins_below,  // new sample lands at or below lower one
  output swm_pkg::entry_t     cur,
  output logic                del,
  output logic                hit         // empty, or holds a larger value
);

  swm_pkg::entry_t self_r;
  swm_pkg::entry_t self_nxt;
  swm_pkg::entry_t lo_a;
  swm_pkg::entry_t hi_a;
  swm_pkg::entry_t new_e;
  logic            v_self;

  assign cur = self_r;

  // local compares against the broadcast
  always_comb begin
    v_self = self_r.vld & ~ctrl.clear;
    del    = v_self && (self_r.age == ctrl.tgt_age);
    hit    = !v_self || ($signed(self_r.key) > $signed(ctrl.new_key));
  end

  // entries at this and the lower place once the removal has closed up
  always_comb begin
    lo_a     = dle_below ? self_r : below;
    lo_a.vld = lo_a.vld & ~ctrl.clear;
    lo_a.age = lo_a.age + swm_pkg::AGE_W'(ctrl.aging);
    hi_a     = dle_self ? above : self_r;
    hi_a.vld = hi_a.vld & ~ctrl.clear;
    hi_a.age = hi_a.age + swm_pkg::AGE_W'(ctrl.aging);
    new_e.vld = 1'b1;
    new_e.age = '0;
    new_e.key = ctrl.new_key;
  end

  // pick the next entry
  always_comb begin
    self_nxt = self_r;
    if (ctrl.en) begin
      if (ctrl.insert && ins_below) begin
        self_nxt = lo_a;
      end else if (ctrl.insert && ins_self) begin
        self_nxt = new_e;
      end else begin
        self_nxt = hi_a;
      end
    end
  end

  // entry register, only the valid flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_r.vld <= 1'b0;
    end else begin
      self_r <= self_nxt;
    end
  end

endmodule

// ===== src/swm_chain.sv =====
// ----------------------------------------------------------------------------
// swm_chain: row of sorted window cells
// Wires each cell to its neighbors and derives where the removed entry and
// the new sample sit, with a prefix OR over the removal flags.
// ----------------------------------------------------------------------------
module swm_chain (
  input  logic                       clk,
  input  logic                       rst_n,
  input  swm_pkg::step_ctrl_t        ctrl,
  output logic signed [swm_pkg::SAMPLE_W-1:0] med_keys [swm_pkg::MED_N],
  output logic                       del_any
);

  localparam int W = swm_pkg::WINDOW_MAX;
  localparam int L = swm_pkg::LVL_N;

  swm_pkg::entry_t cur [W];
  logic [W-1:0]    del;
  logic [W-1:0]    dle;
  logic [W:0]      hx;
  logic [W-1:0]    ins;
  logic [W-1:0]    pre [L+1];

  // prefix OR of the removal flags, log depth
  always_comb begin
    int l;
    int i;
    pre[0] = del;
    for (l = 0; l < L; l++) begin
      for (i = 0; i < W; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
    dle = pre[L];
  end

  // insertion flags on the closed-up chain
  assign hx[W] = 1'b1;
  always_comb begin
    int i;
    for (i = 0; i < W; i++) begin
      ins[i] = dle[i] ? hx[i+1] : hx[i];
    end
  end

  assign del_any = dle[W-1];

  // the cells
  for (genvar g = 0; g < W; g++) begin : g_cell
    swm_pkg::entry_t below_e;
    swm_pkg::entry_t above_e;
    logic            dle_lo;
    logic            ins_lo;

    if (g == 0) begin : g_first
      assign below_e = '0;
      assign dle_lo  = 1'b0;
      assign ins_lo  = 1'b0;
    end else begin : g_mid
      assign below_e = cur[g-1];
      assign dle_lo  = dle[g-1];
      assign ins_lo  = ins[g-1];
    end

    if (g == W - 1) begin : g_last
      assign above_e = '0;
    end else begin : g_inner
      assign above_e = cur[g+1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .below     (below_e),
      .above     (above_e),
      .dle_self  (dle[g]),
      .dle_below (dle_lo),
      .ins_self  (ins[g]),
      .ins_below (ins_lo),
      .cur       (cur[g]),
      .del       (del[g]),
      .hit       (hx[g])
    );
  end

  // lower half of the chain feeds the median pick
  for (genvar k = 0; k < swm_pkg::MED_N; k++) begin : g_med
    assign med_keys[k] = cur[k].key;
  end

endmodule

// ===== src/sliding_window_median_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_top: running median filter over a sliding window
// Keeps the latest window_size samples sorted in a chain of cells and
// reports the lower median once the window is full.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed sample per transaction, in_tuser = sequence start,
//           which empties the window before the sample is taken in.
//   out_* : lower median of the full window, one transaction per sample
//           that leaves the window full; none while it is filling.
//   cfg_* : window size write (0 acts as 1, above 64 acts as 64), only
//           while the block is idle.
// Throughput is one sample per cycle while in_tready is high: every
// cell compares against the new sample and shifts by at most one place
// in the same cycle. When a sample is accepted, the chain and the pending
// stage update together, and out_tvalid rises once the result moves on
// into the output register. After the window size shrinks, the chain
// drops its oldest entries one per cycle, with in_tready low, before the
// next sample. Reset empties the window and sets the size to 3. When the
// receiver stalls, one result waits in the output register and one more in
// the pending stage; in_tready falls when both are occupied or entries drain.
// ----------------------------------------------------------------------------
module sliding_window_median_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input samples
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [swm_pkg::TDATA_W-1:0]   in_tdata,   // [31:0] sample
  input  logic                          in_tuser,   // [0] sequence_start
  // median results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [swm_pkg::TDATA_W-1:0]   out_tdata,  // [31:0] median
  // window size register
  input  logic                          cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_wr_data
);

  localparam int CNT_W = swm_pkg::CNT_W;
  localparam int SZ_W  = swm_pkg::SZ_W;

  logic [swm_pkg::CFG_W-1:0]           ws_r;
  logic [CNT_W-1:0]                    fill_r;
  logic [CNT_W-1:0]                    fill_nxt;
  logic                                pend_r;
  logic                                pend_nxt;
  logic                                out_valid_r;
  logic                                out_valid_nxt;
  logic signed [swm_pkg::SAMPLE_W-1:0] out_data_r;
  logic signed [swm_pkg::SAMPLE_W-1:0] out_data_nxt;

  logic [SZ_W-1:0]                     ws_ext;
  logic [SZ_W-1:0]                     size_eff;
  logic [CNT_W-1:0]                    size_cnt;
  logic [CNT_W-1:0]                    mid_full;
  logic [swm_pkg::MID_W-1:0]           mid;
  logic                                purge;
  logic                                step;
  logic                                move;
  logic                                emit;
  logic                                del_any;
  logic [CNT_W-1:0]                    base;
  swm_pkg::step_ctrl_t                 ctrl;
  logic signed [swm_pkg::SAMPLE_W-1:0] med_keys [swm_pkg::MED_N];

  // effective window size
  always_comb begin
    ws_ext = SZ_W'(ws_r);
    if (ws_r == '0) begin
      size_eff = SZ_W'(1);
    end else if (ws_ext > SZ_W'(swm_pkg::WINDOW_MAX)) begin
      size_eff = SZ_W'(swm_pkg::WINDOW_MAX);
    end else begin
      size_eff = ws_ext;
    end
    size_cnt = CNT_W'(size_eff);
    mid_full = (size_cnt - CNT_W'(1)) >> 1;
    mid      = mid_full[swm_pkg::MID_W-1:0];
  end

  // handshake and drain of excess entries after a size change
  assign purge      = fill_r > size_cnt;
  assign move       = !out_valid_r || out_tready;
  assign in_tready  = !purge && (!pend_r || move);
  assign step       = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = swm_pkg::TDATA_W'(out_data_r);

  // broadcast to the chain
  always_comb begin
    ctrl.en      = step || purge;
    ctrl.insert  = step;
    ctrl.aging   = step;
    ctrl.clear   = step && in_tuser;
    ctrl.tgt_age = step ? swm_pkg::AGE_W'(size_cnt - CNT_W'(1))
                        : swm_pkg::AGE_W'(fill_r - CNT_W'(1));
    ctrl.new_key = in_tdata[swm_pkg::SAMPLE_W-1:0];
  end

  swm_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .med_keys (med_keys),
    .del_any  (del_any)
  );

  // fill count and result flag
  always_comb begin
    base     = ctrl.clear ? '0 : fill_r;
    fill_nxt = fill_r;
    if (step) begin
      fill_nxt = base - CNT_W'(del_any) + CNT_W'(1);
    end else if (purge) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
    emit = step && (fill_nxt == size_cnt);
  end

  // pending stage and output register
  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (move) begin
      out_valid_nxt = pend_r;
      out_data_nxt  = med_keys[mid];
      pend_nxt      = 1'b0;
    end
    if (step) begin
      pend_nxt = emit;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= swm_pkg::CFG_W'(swm_pkg::CFG_RESET);
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ws_r <= cfg_wr_data;
      end
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/tb_sliding_window_median_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_top: self-checking bench of the running median filter
// Streams signed samples through the filter with bursty input and a stalling
// receiver, keeps a sorted window with age tags of its own to predict each
// lower median, and compares every output transaction in order. Phases run
// at several window sizes, including zero, one, the maximum and above it,
// with shrinking and growing sizes between phases.
// ----------------------------------------------------------------------------

// expected medians for the samples that went in
class median_scoreboard;
  localparam int WMAX = swm_pkg::WINDOW_MAX;

  logic signed [swm_pkg::SAMPLE_W-1:0] win_vals [WMAX];
  int                                  win_ages [WMAX];
  int                                  fill_cnt;
  int                                  win_size;
  logic signed [swm_pkg::SAMPLE_W-1:0] expected_medians [$];
  int                                  mismatches;

  function new();
    fill_cnt   = 0;
    win_size   = swm_pkg::CFG_RESET;
    mismatches = 0;
    foreach (win_vals[i]) begin
      win_vals[i] = '0;
      win_ages[i] = 0;
    end
  endfunction

  function void set_window(int size);
    win_size = size;
  endfunction

  // age the window, insert the sample in order, queue a median once full
  function void take_sample(logic signed [swm_pkg::SAMPLE_W-1:0] smp, bit seq_start);
    int eff;
    int kept;
    int pos;
    eff = (win_size == 0) ? 1 : ((win_size > WMAX) ? WMAX : win_size);
    if (seq_start) fill_cnt = 0;
    kept = 0;
    for (int i = 0; i < fill_cnt; i++) begin
      if (win_ages[i] + 1 < eff) begin
        win_vals[kept] = win_vals[i];
        win_ages[kept] = win_ages[i] + 1;
        kept++;
      end
    end
    fill_cnt = kept;
    pos = fill_cnt;
    while (pos > 0 && win_vals[pos-1] > smp) begin
      win_vals[pos] = win_vals[pos-1];
      win_ages[pos] = win_ages[pos-1];
      pos--;
    end
    win_vals[pos] = smp;
    win_ages[pos] = 0;
    fill_cnt++;
    if (fill_cnt == eff) expected_medians = {expected_medians, win_vals[(eff-1)/2]};
  endfunction

  // compare one median transaction with the oldest prediction
  function void check_median(logic signed [swm_pkg::SAMPLE_W-1:0] got);
    logic signed [swm_pkg::SAMPLE_W-1:0] exp_med;
    if (expected_medians.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected median %0d, none pending", got);
    end else begin
      exp_med = expected_medians.pop_front();
      if (exp_med !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("median mismatch: expected %0d, got %0d", exp_med, got);
      end
    end
  endfunction

  function int outstanding();
    return expected_medians.size();
  endfunction

  function bit passed();
    return (mismatches == 0) && (expected_medians.size() == 0);
  endfunction
endclass

module tb_sliding_window_median_top;

  localparam int SAMPLE_W    = swm_pkg::SAMPLE_W;
  localparam int TDATA_W     = swm_pkg::TDATA_W;
  localparam int CFG_W       = swm_pkg::CFG_W;
  localparam int WINDOW_MAX  = swm_pkg::WINDOW_MAX;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 4;
  localparam int PHASE_ITEMS = 90;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata    = '0;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;

  median_scoreboard sb = new();
  int               cycles     = 0;
  int               burst_left = 0;
  int               rx_mode    = 0;
  int               rx_left    = 0;

  sliding_window_median_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: switches between always ready, coin flips and long stalls
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      0:       out_tready = 1'b1;
      1:       out_tready = $urandom_range(0, 1);
      default: out_tready = ($urandom_range(0, 7) == 0);
    endcase
  end

  // check each median transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_median(out_tdata[SAMPLE_W-1:0]);
  end

  task automatic idle_gap(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
  endtask

  // one sample transaction, bursts of random length with random gaps between
  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, bit seq_start);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = TDATA_W'(smp);
    in_tuser  = seq_start;
    do @(posedge clk); while (!in_tready);
    sb.take_sample(smp, seq_start);
  endtask

  // hold input until every predicted median has come out
  task automatic wait_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // window size write, only with the block idle
  task automatic write_window(int size);
    wait_results();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = CFG_W'(size);
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_window(size);
  endtask

  // extremes, a narrow range that gives many equal values, or anything
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b1, {(SAMPLE_W-1){1'b0}}};
          1:       v = {1'b0, {(SAMPLE_W-1){1'b1}}};
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2:    v = SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] s_min;
    logic signed [SAMPLE_W-1:0] s_max;
    int                         sizes [9];
    s_min = {1'b1, {(SAMPLE_W-1){1'b0}}};
    s_max = {1'b0, {(SAMPLE_W-1){1'b1}}};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // window of three after reset: extremes, equal values, sequence restart
    send_sample(s_min, 1'b1);
    send_sample(s_max, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(42, 1'b1);
    send_sample(7, 1'b0);
    send_sample(42, 1'b0);

    // grow mid-stream: no median until five are held
    write_window(5);
    send_sample(1, 1'b0);
    send_sample(2, 1'b0);
    send_sample(s_max, 1'b0);

    // shrink mid-stream: refills to two at once
    write_window(2);
    send_sample(s_min, 1'b0);
    send_sample(s_max, 1'b0);
    send_sample(s_max, 1'b0);

    // size zero acts as one
    write_window(0);
    send_sample(s_min, 1'b0);
    send_sample(s_max, 1'b0);
    send_sample(-7, 1'b1);

    // random phases over a spread of window sizes
    sizes = '{1, 64, (1 << CFG_W) - 1, 2, 4, 0, $urandom_range(1, WINDOW_MAX),
              $urandom_range(5, 12), 33};
    foreach (sizes[p]) begin
      write_window(sizes[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 149) == 0) wait_results();
        send_sample(pick_sample(), ($urandom_range(0, 39) == 0));
      end
    end

    // drain, then let the pipeline settle
    wait_results();
    repeat (10) @(posedge clk);
    if (sb.passed()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/swm_pkg.sv
src/swm_cell.sv
src/swm_chain.sv
src/sliding_window_median_top.sv
tb/tb_sliding_window_median_top.sv
